/* src/spf_pkg.sv */
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants of the smallest-prime-factor sieve
// Payload structs for the request and response channels, command and status
// codes, and the defaults for the table size.
// ----------------------------------------------------------------------------
`default_nettype none

package spf_pkg;

   // Width of the numeric payload fields and of the limit register.
   localparam int FIELD_BITS  = 16;
   localparam int STATUS_BITS = 2;

   // Default address width of the factor table.
   localparam int VALUE_BITS_DEF = 16;

   // Most factor results returned for one query.
   localparam int MAX_RESULTS  = 16;
   localparam int RES_CNT_BITS = $clog2(MAX_RESULTS);

   // Limit register value after reset.
   localparam logic [FIELD_BITS-1:0] LIMIT_RESET = 16'hFFFF;

   // Command codes.
   localparam logic CMD_BUILD     = 1'b0;
   localparam logic CMD_FACTORIZE = 1'b1;

   // Response status codes.
   localparam logic [STATUS_BITS-1:0] ST_FACTOR = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DONE   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_ONE    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_ERROR  = 2'd3;

   typedef struct packed {
      logic                  command;
      logic [FIELD_BITS-1:0] query_value;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0]  prime_factor;
      logic [STATUS_BITS-1:0] status;
      logic                   last_result;
   } rsp_type;

endpackage

`default_nettype wire

/* src/smallest_prime_factor_sieve_unit.sv */
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve_unit: factor table with factorization queries
// Builds a smallest-prime-factor table with the sieve of Eratosthenes and
// answers factorization requests from it.
// ----------------------------------------------------------------------------
// The unit takes one request at a time and drops req_ready until the last
// response of that request has been loaded into the output register, so the
// next request can be taken while that response still waits for rsp_ready.
// A build request (command 0) sweeps the table three times through its one
// write and one read port: a clearing pass over entries zero through L, the
// sieve (a read and a check for each candidate up to sqrt(L), plus a read and
// a write for each multiple visited), and a final pass that turns every empty
// entry from two to L into a prime, where L is the built limit. It ends with a
// single done response. For each prime factor, a factorize request reads the
// table entry and checks it, starts the restoring divider, waits for the
// division, takes the quotient and hands the factor to the output register; a
// single-response case (error, value one) goes straight to the output
// register. An untaken response still held in the output register stalls the
// unit. The divider bit loop sets the factorize rate and the table port sets
// the build time. csr_wr_data is the sieve limit used by the next build; write
// it only while no request is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module smallest_prime_factor_sieve_unit #(
   parameter int VALUE_BITS = spf_pkg::VALUE_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire spf_pkg::req_type                 req_data,
   // Response channel.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output spf_pkg::rsp_type                      rsp_data,
   // Limit register write port.
   input  wire logic                             csr_wr_en,
   input  wire logic [spf_pkg::FIELD_BITS-1:0]   csr_wr_data
);

   localparam int VB = VALUE_BITS;
   localparam int CB = spf_pkg::RES_CNT_BITS;
   localparam logic [VB-1:0] TblMax = {VB{1'b1}};

   // Sequencer state codes.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLR    = 4'd1;
   localparam logic [3:0] S_SV_RD  = 4'd2;
   localparam logic [3:0] S_SV_CHK = 4'd3;
   localparam logic [3:0] S_MK_RD  = 4'd4;
   localparam logic [3:0] S_MK_WR  = 4'd5;
   localparam logic [3:0] S_FL_RD  = 4'd6;
   localparam logic [3:0] S_FL_WR  = 4'd7;
   localparam logic [3:0] S_Q_RD   = 4'd8;
   localparam logic [3:0] S_Q_CHK  = 4'd9;
   localparam logic [3:0] S_Q_DIV  = 4'd10;
   localparam logic [3:0] S_EMIT   = 4'd11;

   // Control state.
   logic [3:0]                        state_ff, state_in;
   logic                              table_ready_ff, table_ready_in;
   logic [VB-1:0]                     built_lim_ff, built_lim_in;
   logic [spf_pkg::FIELD_BITS-1:0]    sieve_limit_ff, sieve_limit_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [VB-1:0]                     lim_ff, lim_in;
   logic [VB-1:0]                     idx_ff, idx_in;
   logic [VB:0]                       sq_ff, sq_in;
   logic [VB:0]                       j_ff, j_in;
   logic [VB-1:0]                     v_ff, v_in;
   logic [VB-1:0]                     p_ff, p_in;
   logic [CB-1:0]                     cnt_ff, cnt_in;
   logic [VB-1:0]                     em_factor_ff, em_factor_in;
   logic [spf_pkg::STATUS_BITS-1:0]   em_status_ff, em_status_in;
   logic                              em_last_ff, em_last_in;
   spf_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   // Table port.
   logic                              ram_we;
   logic [VB-1:0]                     ram_waddr;
   logic [VB-1:0]                     ram_wdata;
   logic [VB-1:0]                     ram_raddr;
   logic [VB-1:0]                     ram_rdata;

   // Divider port.
   logic                              div_start;
   logic                              div_busy;
   logic                              div_done;
   logic [VB-1:0]                     div_quo;
   logic [VB-1:0]                     div_rem;

   // Helpers.
   logic                              out_free;
   logic [31:0]                       cfg_wide;
   logic [31:0]                       qv_wide;
   logic [31:0]                       fac_wide;
   logic [VB-1:0]                     lim_calc;
   logic [VB:0]                       j_next;
   logic [VB-1:0]                     q_val;
   logic [VB-1:0]                     p_val;

   spf_ram #(
      .ADDR_BITS (VB),
      .DATA_BITS (VB)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   spf_div #(
      .WIDTH (VB)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (v_ff),
      .divisor   (p_ff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // The build limit saturates to the largest table address.
   assign cfg_wide = 32'(sieve_limit_ff);
   assign lim_calc = (cfg_wide > 32'(TblMax)) ? TblMax : cfg_wide[VB-1:0];
   assign qv_wide  = 32'(req_data.query_value);
   assign fac_wide = 32'(em_factor_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign j_next   = j_ff + {1'b0, idx_ff};

   always_comb begin
      state_in       = state_ff;
      table_ready_in = table_ready_ff;
      built_lim_in   = built_lim_ff;
      sieve_limit_in = csr_wr_en ? csr_wr_data : sieve_limit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      lim_in         = lim_ff;
      idx_in         = idx_ff;
      sq_in          = sq_ff;
      j_in           = j_ff;
      v_in           = v_ff;
      p_in           = p_ff;
      cnt_in         = cnt_ff;
      em_factor_in   = em_factor_ff;
      em_status_in   = em_status_ff;
      em_last_in     = em_last_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = '0;
      ram_raddr      = idx_ff;
      div_start      = 1'b0;
      req_ready      = 1'b0;
      q_val          = div_quo;
      p_val          = p_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               em_factor_in = '0;
               em_last_in   = 1'b1;
               cnt_in       = '0;
               if (req_data.command == spf_pkg::CMD_BUILD) begin
                  lim_in   = lim_calc;
                  idx_in   = '0;
                  state_in = S_CLR;
               end else if (!table_ready_ff || qv_wide == 32'd0 ||
                            qv_wide > 32'(built_lim_ff)) begin
                  em_status_in = spf_pkg::ST_ERROR;
                  state_in     = S_EMIT;
               end else if (qv_wide == 32'd1) begin
                  em_status_in = spf_pkg::ST_ONE;
                  state_in     = S_EMIT;
               end else begin
                  v_in     = qv_wide[VB-1:0];
                  state_in = S_Q_RD;
               end
            end
         end

         // Clearing pass over entries zero through the limit.
         S_CLR: begin
            ram_we = 1'b1;
            if (idx_ff == lim_ff) begin
               idx_in   = VB'(2);
               sq_in    = (VB+1)'(4);
               state_in = S_SV_RD;
            end else begin
               idx_in = idx_ff + VB'(1);
            end
         end

         // Sieve: stop once the square of the candidate passes the limit.
         S_SV_RD: begin
            if (sq_ff > {1'b0, lim_ff}) begin
               idx_in = VB'(2);
               if (lim_ff < VB'(2)) begin
                  table_ready_in = 1'b1;
                  built_lim_in   = lim_ff;
                  em_status_in   = spf_pkg::ST_DONE;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_FL_RD;
               end
            end else begin
               state_in = S_SV_CHK;
            end
         end

         S_SV_CHK: begin
            if (ram_rdata == '0) begin
               j_in     = sq_ff;
               state_in = S_MK_RD;
            end else begin
               idx_in   = idx_ff + VB'(1);
               sq_in    = sq_ff + {idx_ff, 1'b1};
               state_in = S_SV_RD;
            end
         end

         S_MK_RD: begin
            ram_raddr = j_ff[VB-1:0];
            state_in  = S_MK_WR;
         end

         // Mark an unmarked multiple with the current prime.
         S_MK_WR: begin
            ram_waddr = j_ff[VB-1:0];
            ram_wdata = idx_ff;
            ram_we    = (ram_rdata == '0);
            if (j_next > {1'b0, lim_ff}) begin
               idx_in   = idx_ff + VB'(1);
               sq_in    = sq_ff + {idx_ff, 1'b1};
               state_in = S_SV_RD;
            end else begin
               j_in     = j_next;
               state_in = S_MK_RD;
            end
         end

         S_FL_RD: begin
            state_in = S_FL_WR;
         end

         // Every entry still empty is a prime and holds itself.
         S_FL_WR: begin
            ram_wdata = idx_ff;
            ram_we    = (ram_rdata == '0);
            if (idx_ff == lim_ff) begin
               table_ready_in = 1'b1;
               built_lim_in   = lim_ff;
               em_factor_in   = '0;
               em_status_in   = spf_pkg::ST_DONE;
               em_last_in     = 1'b1;
               state_in       = S_EMIT;
            end else begin
               idx_in   = idx_ff + VB'(1);
               state_in = S_FL_RD;
            end
         end

         S_Q_RD: begin
            ram_raddr = v_ff;
            state_in  = S_Q_CHK;
         end

         S_Q_CHK: begin
            p_in     = (ram_rdata < VB'(2)) ? v_ff : ram_rdata;
            state_in = S_Q_DIV;
         end

         S_Q_DIV: begin
            if (!div_busy && !div_done) begin
               div_start = 1'b1;
            end
            if (div_done) begin
               // A table entry that does not divide the value is taken as
               // the value itself being prime.
               if (div_rem != '0) begin
                  p_val = v_ff;
                  q_val = VB'(1);
               end
               em_factor_in = p_val;
               em_status_in = spf_pkg::ST_FACTOR;
               em_last_in   = (q_val == VB'(1)) ||
                              (cnt_ff == CB'(spf_pkg::MAX_RESULTS - 1));
               v_in         = q_val;
               cnt_in       = cnt_ff + CB'(1);
               state_in     = S_EMIT;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.prime_factor = fac_wide[spf_pkg::FIELD_BITS-1:0];
               rsp_data_in.status       = em_status_ff;
               rsp_data_in.last_result  = em_last_ff;
               state_in                 = em_last_ff ? S_IDLE : S_Q_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         table_ready_ff <= 1'b0;
         built_lim_ff   <= '0;
         sieve_limit_ff <= spf_pkg::LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         table_ready_ff <= table_ready_in;
         built_lim_ff   <= built_lim_in;
         sieve_limit_ff <= sieve_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      lim_ff       <= lim_in;
      idx_ff       <= idx_in;
      sq_ff        <= sq_in;
      j_ff         <= j_in;
      v_ff         <= v_in;
      p_ff         <= p_in;
      cnt_ff       <= cnt_in;
      em_factor_ff <= em_factor_in;
      em_status_ff <= em_status_in;
      em_last_ff   <= em_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A factor transfer always carries a real prime.
   a_factor_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == spf_pkg::ST_FACTOR
      |-> rsp_data.prime_factor > 16'd1)
      else $error("factor response without a prime");

   // Done, value-one and error transfers are single and carry no factor.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != spf_pkg::ST_FACTOR
      |-> rsp_data.last_result && rsp_data.prime_factor == 16'd0)
      else $error("non-factor response is not a lone final transfer");

   // The table is only written by the build passes.
   a_build_writes: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == S_CLR || state_ff == S_MK_WR || state_ff == S_FL_WR)
      else $error("table written outside a build");

   // The divider is never restarted while it is still working.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy && state_ff == S_Q_DIV)
      else $error("divider restarted while busy");

   // Once built, the table stays valid.
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      table_ready_ff |=> table_ready_ff)
      else $error("table ready flag dropped");

endmodule

`default_nettype wire

/* src/spf_ram.sv */
// ----------------------------------------------------------------------------
// spf_ram: factor table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_ram #(
   parameter int ADDR_BITS = spf_pkg::VALUE_BITS_DEF,
   parameter int DATA_BITS = spf_pkg::VALUE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   localparam int Depth = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem_ff [Depth];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/spf_div.sv */
// ----------------------------------------------------------------------------
// spf_div: iterative restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle when the
// quotient and remainder are valid. They hold until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_div #(
   parameter int WIDTH = spf_pkg::VALUE_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic      [WIDTH-1:0] quotient,
   output logic      [WIDTH-1:0] remainder
);

   localparam int CntBits = $clog2(WIDTH + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [WIDTH:0]     rem_ff, rem_in;
   logic [WIDTH-1:0]   quo_ff, quo_in;
   logic [WIDTH-1:0]   dvs_ff, dvs_in;
   logic [WIDTH:0]     shifted;
   logic [WIDTH:0]     diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntBits'(WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff;
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntBits'(1);
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[WIDTH-1:0];

endmodule

`default_nettype wire
